### src/edf_annotation_list_parser_defines.svh
// Assertion helpers shared by the parser RTL.
`ifndef EDF_ANNOTATION_LIST_PARSER_DEFINES_SVH
`define EDF_ANNOTATION_LIST_PARSER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define EDF_ALP_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define EDF_ALP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/edf_alp_pkg.sv
package edf_alp_pkg;

    localparam int FRACTION_DIGITS = 3;

    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 41;
    localparam int ONSET_W = 41;
    localparam int DUR_W   = 40;

    // fraction digit counter, must reach FRACTION_DIGITS
    localparam int FCNT_W = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);
    // width of 10^FRACTION_DIGITS
    localparam int POW_W  = $clog2((10 ** FRACTION_DIGITS) + 1);

    localparam logic [ACC_W-1:0] ONSET_CAP = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] DUR_CAP   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ONSET_MAX = {1'b0, {(ACC_W-1){1'b1}}};

    localparam logic [63:0] TEN = 64'd10;

    // byte codes
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TEXT_SEP = 8'h14;
    localparam logic [BYTE_W-1:0] CH_DUR_SEP  = 8'h15;
    localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_POINT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DIGIT,
        CLS_POINT,
        CLS_PLUS,
        CLS_MINUS,
        CLS_TEXT_SEP,
        CLS_DUR_SEP,
        CLS_NUL
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_q_item;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [FRACTION_DIGITS:0][ACC_W-1:0] t_lim_tab;
    typedef logic [FRACTION_DIGITS:0][POW_W-1:0] t_pow_tab;

    // entry k: largest accumulator that still fits cap after k decimal shifts
    function automatic t_lim_tab make_lim_tab(input logic [63:0] cap);
        t_lim_tab    tab;
        logic [63:0] v;
        v = cap;
        for (int k = 0; k <= FRACTION_DIGITS; k++) begin
            tab[k] = v[ACC_W-1:0];
            v      = v / TEN;
        end
        return tab;
    endfunction

    function automatic t_pow_tab make_pow_tab();
        t_pow_tab    tab;
        logic [63:0] v;
        v = 64'd1;
        for (int k = 0; k <= FRACTION_DIGITS; k++) begin
            tab[k] = v[POW_W-1:0];
            v      = v * TEN;
        end
        return tab;
    endfunction

    localparam t_lim_tab ONSET_LIM = make_lim_tab(64'(ONSET_CAP));
    localparam t_lim_tab DUR_LIM   = make_lim_tab(64'(DUR_CAP));
    localparam t_pow_tab POW10     = make_pow_tab();

endpackage

### src/edf_alp_if.sv
// Record byte channel.
interface edf_alp_in_if;
    logic                              valid;
    logic                              ready;
    logic [edf_alp_pkg::BYTE_W-1:0]    in_byte;
    logic                              record_last;

    modport source (output valid, output in_byte, output record_last, input ready);
    modport sink   (input valid, input in_byte, input record_last, output ready);
endinterface

// Annotation result channel.
interface edf_alp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [edf_alp_pkg::ONSET_W-1:0] onset_ms;
    logic [edf_alp_pkg::DUR_W-1:0]        duration_ms;
    logic                                 has_duration;
    logic [edf_alp_pkg::BYTE_W-1:0]       text_byte;
    logic                                 text_last;

    modport source (output valid, output kind, output onset_ms, output duration_ms,
                    output has_duration, output text_byte, output text_last,
                    input ready);
    modport sink   (input valid, input kind, input onset_ms, input duration_ms,
                    input has_duration, input text_byte, input text_last,
                    output ready);
endinterface

### src/edf_annotation_list_parser.sv
// Channel  Dir  Payload                                            Accepted when
// i_rec    in   in_byte[7:0], record_last                          valid && ready
// o_ann    out  kind, onset_ms[40:0] s, duration_ms[39:0],         valid && ready
//               has_duration, text_byte[7:0], text_last
//
// One byte per cycle sustained while o_ann is not stalled. A byte accepted into
// the queue waits at the queue head, the parse stage works on it there, and its
// result is registered in the output register. Text results trail by one more item,
// since a text byte is held until the next byte shows whether it ends the text.
// The parse stage handles one byte per cycle unless o_ann stalls: a times-ten add
// and compare per digit, and one multiply by a power of ten at a number terminator.
// Reset is synchronous, active low; it clears the queue, phase and output valid.
// A stalled output holds the parse stage; the two-entry queue keeps i_rec.ready
// high until it fills.
module edf_annotation_list_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    edf_alp_in_if.sink      i_rec,
    edf_alp_out_if.source   o_ann
);

    // front -> queue
    logic                   w_push;
    edf_alp_pkg::t_q_item   w_push_item;
    logic                   w_q_full;

    // queue -> back
    logic                   w_q_valid;
    edf_alp_pkg::t_q_item   w_q_item;
    logic                   w_pop;

    // classify raw bytes, stall when the queue is full
    edf_alp_front u_front (
        .i_rec    (i_rec),
        .i_q_full (w_q_full),
        .o_q_push (w_push),
        .o_q_item (w_push_item)
    );

    // short decoupling queue between classify and parse
    edf_alp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // phase machine, number accumulation, text hold-back and output register
    edf_alp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_pop),
        .o_ann     (o_ann)
    );

endmodule

### src/edf_alp_front.sv
module edf_alp_front (
    edf_alp_in_if.sink             i_rec,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output edf_alp_pkg::t_q_item   o_q_item
);

    edf_alp_pkg::t_cls w_cls;

    always_comb begin
        if (i_rec.in_byte >= edf_alp_pkg::CH_ZERO && i_rec.in_byte <= edf_alp_pkg::CH_NINE) begin
            w_cls = edf_alp_pkg::CLS_DIGIT;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_POINT) begin
            w_cls = edf_alp_pkg::CLS_POINT;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_PLUS) begin
            w_cls = edf_alp_pkg::CLS_PLUS;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_MINUS) begin
            w_cls = edf_alp_pkg::CLS_MINUS;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_TEXT_SEP) begin
            w_cls = edf_alp_pkg::CLS_TEXT_SEP;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_DUR_SEP) begin
            w_cls = edf_alp_pkg::CLS_DUR_SEP;
        end else if (i_rec.in_byte == edf_alp_pkg::CH_NUL) begin
            w_cls = edf_alp_pkg::CLS_NUL;
        end else begin
            w_cls = edf_alp_pkg::CLS_OTHER;
        end
    end

    assign i_rec.ready    = !i_q_full;
    assign o_q_push       = i_rec.valid && !i_q_full;
    assign o_q_item.cls   = w_cls;
    assign o_q_item.data  = i_rec.in_byte;
    assign o_q_item.last  = i_rec.record_last;

endmodule

### src/edf_alp_queue.sv
`include "edf_annotation_list_parser_defines.svh"

module edf_alp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  edf_alp_pkg::t_q_item   i_item,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output edf_alp_pkg::t_q_item   o_item
);

    edf_alp_pkg::t_q_item                 r_mem [edf_alp_pkg::Q_DEPTH];
    logic [edf_alp_pkg::Q_AW-1:0]         r_wr_ptr;
    logic [edf_alp_pkg::Q_AW-1:0]         r_rd_ptr;
    logic [edf_alp_pkg::Q_CW-1:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == edf_alp_pkg::Q_CW'(edf_alp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    `EDF_ALP_ASSERT(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `EDF_ALP_ASSERT(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")

endmodule

### src/edf_alp_back.sv
`include "edf_annotation_list_parser_defines.svh"

module edf_alp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  edf_alp_pkg::t_q_item   i_q_item,
    output logic                   o_q_pop,
    edf_alp_out_if.source          o_ann
);

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_ONSET,
        PH_DUR,
        PH_AFTER_SEP,
        PH_TEXT,
        PH_PAD,
        PH_SKIP
    } t_phase;

    localparam int ACC_W = edf_alp_pkg::ACC_W;
    localparam int DUR_W = edf_alp_pkg::DUR_W;
    localparam int FCNT_W = edf_alp_pkg::FCNT_W;
    localparam int POW_W = edf_alp_pkg::POW_W;

    t_phase                    r_phase, n_phase;
    logic [ACC_W-1:0]          r_onset_acc, n_onset_acc;
    logic                      r_neg, n_neg;
    logic [DUR_W-1:0]          r_dur_acc, n_dur_acc;
    logic                      r_dur_seen, n_dur_seen;
    logic                      r_point_seen, n_point_seen;
    logic [FCNT_W-1:0]         r_frac_cnt, n_frac_cnt;
    logic                      r_digit_seen, n_digit_seen;
    logic [7:0]                r_held_byte, n_held_byte;
    logic                      r_held_valid, n_held_valid;

    logic                      r_out_valid, n_out_valid;
    logic                      r_out_kind;
    logic [ACC_W-1:0]          r_out_onset;
    logic [DUR_W-1:0]          r_out_dur;
    logic                      r_out_has_dur;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    logic                      w_go;
    logic                      w_emit;
    logic                      w_err;
    logic                      w_emit_last;
    logic                      w_sign_chk;
    logic                      w_is_onset;
    logic [ACC_W-1:0]          w_acc;
    logic [ACC_W-1:0]          w_cap;
    logic [ACC_W+3:0]          w_push_full;
    logic [ACC_W-1:0]          w_pushed;
    logic [FCNT_W-1:0]         w_k;
    logic [ACC_W-1:0]          w_lim;
    logic [ACC_W+POW_W-1:0]    w_scale_prod;
    logic [ACC_W-1:0]          w_scaled;
    logic                      w_frac_full;
    logic [ACC_W-1:0]          w_onset_out;

    // shared decimal unit, onset or duration depending on phase
    assign w_is_onset   = (r_phase == PH_ONSET);
    assign w_acc        = w_is_onset ? r_onset_acc : {1'b0, r_dur_acc};
    assign w_cap        = w_is_onset ? edf_alp_pkg::ONSET_CAP : edf_alp_pkg::DUR_CAP;
    assign w_push_full  = {1'b0, w_acc, 3'b000} + {3'b000, w_acc, 1'b0}
                          + (ACC_W+4)'(i_q_item.data[3:0]);
    assign w_pushed     = (w_push_full > {4'b0000, w_cap}) ? w_cap : w_push_full[ACC_W-1:0];

    // missing fraction digits: one multiply by 10^k with saturation
    assign w_k          = FCNT_W'(edf_alp_pkg::FRACTION_DIGITS) - r_frac_cnt;
    assign w_lim        = w_is_onset ? edf_alp_pkg::ONSET_LIM[w_k] : edf_alp_pkg::DUR_LIM[w_k];
    assign w_scale_prod = w_acc * edf_alp_pkg::POW10[w_k];
    assign w_scaled     = (w_acc > w_lim) ? w_cap : w_scale_prod[ACC_W-1:0];
    assign w_frac_full  = (r_frac_cnt >= FCNT_W'(edf_alp_pkg::FRACTION_DIGITS));

    assign w_onset_out  = r_neg ? (ACC_W'(0) - r_onset_acc)
                        : (r_onset_acc[ACC_W-1] ? edf_alp_pkg::ONSET_MAX : r_onset_acc);

    assign w_go         = i_q_valid && (!r_out_valid || o_ann.ready);
    assign o_q_pop      = w_go;

    always_comb begin
        n_phase      = r_phase;
        n_onset_acc  = r_onset_acc;
        n_neg        = r_neg;
        n_dur_acc    = r_dur_acc;
        n_dur_seen   = r_dur_seen;
        n_point_seen = r_point_seen;
        n_frac_cnt   = r_frac_cnt;
        n_digit_seen = r_digit_seen;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        w_emit       = 1'b0;
        w_err        = 1'b0;
        w_emit_last  = 1'b0;
        w_sign_chk   = 1'b0;

        if (w_go) begin
            unique case (r_phase)
                PH_SIGN: begin
                    if (r_held_valid) begin
                        w_emit       = 1'b1;
                        w_emit_last  = 1'b1;
                        n_held_valid = 1'b0;
                    end
                    w_sign_chk = 1'b1;
                end
                PH_PAD: begin
                    w_sign_chk = (i_q_item.cls != edf_alp_pkg::CLS_NUL);
                end
                PH_ONSET, PH_DUR: begin
                    case (i_q_item.cls) inside
                        edf_alp_pkg::CLS_DIGIT: begin
                            n_digit_seen = 1'b1;
                            if (!(r_point_seen && w_frac_full)) begin
                                if (w_is_onset) begin
                                    n_onset_acc = w_pushed;
                                end else begin
                                    n_dur_acc = w_pushed[DUR_W-1:0];
                                end
                                if (r_point_seen) begin
                                    n_frac_cnt = r_frac_cnt + 1'b1;
                                end
                            end
                        end
                        edf_alp_pkg::CLS_POINT: begin
                            if (r_point_seen) begin
                                w_err = 1'b1;
                            end else begin
                                n_point_seen = 1'b1;
                            end
                        end
                        edf_alp_pkg::CLS_TEXT_SEP, edf_alp_pkg::CLS_DUR_SEP: begin
                            if (i_q_item.cls == edf_alp_pkg::CLS_DUR_SEP && !w_is_onset) begin
                                w_err = 1'b1;
                            end else if (!r_digit_seen) begin
                                w_err = 1'b1;
                            end else begin
                                if (w_is_onset) begin
                                    n_onset_acc = w_scaled;
                                end else begin
                                    n_dur_acc = w_scaled[DUR_W-1:0];
                                end
                                n_point_seen = 1'b0;
                                n_frac_cnt   = '0;
                                n_digit_seen = 1'b0;
                                if (i_q_item.cls == edf_alp_pkg::CLS_DUR_SEP) begin
                                    n_dur_seen = 1'b1;
                                    n_dur_acc  = '0;
                                    n_phase    = PH_DUR;
                                end else begin
                                    n_phase = PH_AFTER_SEP;
                                end
                            end
                        end
                        default: begin
                            w_err = 1'b1;
                        end
                    endcase
                    if (w_err) begin
                        w_emit  = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end
                PH_AFTER_SEP: begin
                    if (i_q_item.cls == edf_alp_pkg::CLS_NUL
                        || i_q_item.cls == edf_alp_pkg::CLS_TEXT_SEP) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_held_byte  = i_q_item.data;
                        n_held_valid = 1'b1;
                        n_phase      = PH_TEXT;
                    end
                end
                PH_TEXT: begin
                    w_emit = 1'b1;
                    if (i_q_item.cls == edf_alp_pkg::CLS_TEXT_SEP) begin
                        w_emit_last  = 1'b1;
                        n_held_valid = 1'b0;
                        n_phase      = PH_AFTER_SEP;
                    end else begin
                        n_held_byte = i_q_item.data;
                    end
                end
                default: begin
                end
            endcase

            if (w_sign_chk) begin
                if (i_q_item.cls == edf_alp_pkg::CLS_PLUS
                    || i_q_item.cls == edf_alp_pkg::CLS_MINUS) begin
                    n_neg        = (i_q_item.cls == edf_alp_pkg::CLS_MINUS);
                    n_onset_acc  = '0;
                    n_dur_acc    = '0;
                    n_dur_seen   = 1'b0;
                    n_point_seen = 1'b0;
                    n_frac_cnt   = '0;
                    n_digit_seen = 1'b0;
                    n_phase      = PH_ONSET;
                end else begin
                    n_phase = PH_SKIP;
                end
            end

            if (i_q_item.last) begin
                n_phase = PH_SIGN;
            end
        end

        if (w_go) begin
            n_out_valid = w_emit;
        end else begin
            n_out_valid = r_out_valid && !o_ann.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIGN;
            r_onset_acc  <= '0;
            r_neg        <= 1'b0;
            r_dur_acc    <= '0;
            r_dur_seen   <= 1'b0;
            r_point_seen <= 1'b0;
            r_frac_cnt   <= '0;
            r_digit_seen <= 1'b0;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_onset_acc  <= n_onset_acc;
            r_neg        <= n_neg;
            r_dur_acc    <= n_dur_acc;
            r_dur_seen   <= n_dur_seen;
            r_point_seen <= n_point_seen;
            r_frac_cnt   <= n_frac_cnt;
            r_digit_seen <= n_digit_seen;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
            if (w_go && w_emit) begin
                r_out_kind    <= w_err;
                r_out_onset   <= w_err ? '0 : w_onset_out;
                r_out_dur     <= (w_err || !r_dur_seen) ? '0 : r_dur_acc;
                r_out_has_dur <= !w_err && r_dur_seen;
                r_out_byte    <= w_err ? '0 : r_held_byte;
                r_out_last    <= !w_err && w_emit_last;
            end
        end
    end

    assign o_ann.valid        = r_out_valid;
    assign o_ann.kind         = r_out_kind;
    assign o_ann.onset_ms     = $signed(r_out_onset);
    assign o_ann.duration_ms  = r_out_dur;
    assign o_ann.has_duration = r_out_has_dur;
    assign o_ann.text_byte    = r_out_byte;
    assign o_ann.text_last    = r_out_last;

    `EDF_ALP_ASSERT(a_held_phase, i_clk, i_rst_n, r_held_valid,
        (r_phase == PH_TEXT) || (r_phase == PH_SIGN), "held byte outside text")
    `EDF_ALP_ASSERT(a_acc_range, i_clk, i_rst_n, 1'b1,
        (r_onset_acc <= edf_alp_pkg::ONSET_CAP)
        && (r_frac_cnt <= FCNT_W'(edf_alp_pkg::FRACTION_DIGITS)), "accumulator out of range")
    `EDF_ALP_ASSERT(a_err_clean, i_clk, i_rst_n, r_out_valid && r_out_kind,
        (r_out_onset == '0) && (r_out_dur == '0) && !r_out_has_dur
        && (r_out_byte == '0) && !r_out_last, "error item carries payload")
    `EDF_ALP_ASSERT_NEXT(a_skip_holds, i_clk, i_rst_n,
        w_go && (r_phase == PH_SKIP) && !i_q_item.last,
        (r_phase == PH_SKIP) && !r_out_valid, "skip left early or emitted")

endmodule
